@@ rtl/lkvc_pkg.sv @@
// lkvc_pkg: shared types, widths and codes for the LRU key-value cache.
// No dependencies; every other file imports it.
`timescale 1ns / 1ps

package lkvc_pkg;

  localparam int KEY_W           = 32;
  localparam int VALUE_W         = 32;
  localparam int CAP_W           = 5;
  localparam int MAX_ENTRIES_DEF = 16;

  // APB register map
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_CAPACITY = '0;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);

  // operation codes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  localparam logic signed [VALUE_W-1:0] MISS_VALUE = '1;  // -1
  localparam logic signed [VALUE_W-1:0] PUT_VALUE  = '0;

  typedef struct packed {
    logic                      operation;
    logic signed [KEY_W-1:0]   key;
    logic signed [VALUE_W-1:0] value;
  } lkvc_req_t;

  typedef struct packed {
    logic                      found;
    logic signed [VALUE_W-1:0] read_value;
    logic                      evicted;
  } lkvc_rsp_t;

endpackage

@@ rtl/lkvc_if.sv @@
// lkvc_if: valid/ready channel interfaces for request and response words.
// Depends on lkvc_pkg.
`timescale 1ns / 1ps

interface lkvc_req_if import lkvc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic signed [KEY_W-1:0]   key;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, operation, key, value, input ready);
  modport sink   (input valid, operation, key, value, output ready);
endinterface

interface lkvc_rsp_if import lkvc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic signed [VALUE_W-1:0] read_value;
  logic                      evicted;

  modport source (output valid, found, read_value, evicted, input ready);
  modport sink   (input valid, found, read_value, evicted, output ready);
endinterface

@@ rtl/lkvc_cfg.sv @@
// lkvc_cfg: APB register block holding the capacity register.
// Depends on lkvc_pkg.
`timescale 1ns / 1ps

module lkvc_cfg import lkvc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [CAP_W-1:0]      capacity
);

  logic                 sel_cap;
  logic [REG_IDX_W-1:0] reg_idx;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign sel_cap = (reg_idx == REG_CAPACITY);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (psel && penable && pwrite && pready && sel_cap) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_cap) begin
      prdata = APB_DATA_W'(capacity);
    end
  end

endmodule

@@ rtl/lkvc_store.sv @@
// lkvc_store: entry array (keys, values, valid, recency rank) with the
// combinational lookup and registered update. Depends on lkvc_pkg.
`timescale 1ns / 1ps

module lkvc_store import lkvc_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CAP_W-1:0] capacity,
  input  logic             fire,
  input  lkvc_req_t        req,
  output lkvc_rsp_t        rsp
);

  localparam int RANK_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic signed [KEY_W-1:0]   keys   [MAX_ENTRIES];
  logic signed [VALUE_W-1:0] values [MAX_ENTRIES];
  logic [RANK_W-1:0]         rank   [MAX_ENTRIES];
  logic [RANK_W-1:0]         rank_next [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]    valid, valid_next;
  logic [CNT_W-1:0]          count, count_next;

  logic [MAX_ENTRIES-1:0]    hit_oh, oldest_oh, free_vec, free_oh, slot_oh;
  logic [MAX_ENTRIES-1:0]    key_we, value_we;
  logic [RANK_W-1:0]         hit_rank, last_rank;
  logic signed [VALUE_W-1:0] hit_value;
  logic [CMP_W-1:0]          cap_ext, eff_cap;
  logic                      is_put, hit, insert, evict, full;

  // effective capacity: 0 acts as 1, anything above the array size saturates
  always_comb begin
    cap_ext = CMP_W'(capacity);
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
      eff_cap = CMP_W'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  // ranks of valid entries are always 0..count-1, so the LRU entry is the
  // one holding rank count-1
  assign last_rank = RANK_W'(count - CNT_W'(1));
  assign free_vec  = ~valid;
  assign free_oh   = free_vec & (~free_vec + MAX_ENTRIES'(1));

  always_comb begin
    hit_value = '0;
    hit_rank  = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_oh[i]    = valid[i] && (keys[i] == req.key);
      oldest_oh[i] = valid[i] && (rank[i] == last_rank);
      hit_value    = hit_value | (hit_oh[i] ? values[i] : '0);
      hit_rank     = hit_rank  | (hit_oh[i] ? rank[i]   : '0);
    end
  end

  assign is_put  = (req.operation == OP_PUT);
  assign hit     = |hit_oh;
  assign insert  = is_put && !hit;
  assign full    = (CMP_W'(count) >= eff_cap);
  assign evict   = insert && full && (count != '0);
  assign slot_oh = evict ? oldest_oh : free_oh;

  always_comb begin
    valid_next = valid;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      rank_next[i] = rank[i];
      key_we[i]    = insert && slot_oh[i];
      value_we[i]  = is_put && (hit ? hit_oh[i] : slot_oh[i]);
      if (hit) begin
        if (hit_oh[i]) begin
          rank_next[i] = '0;
        end else if (valid[i] && (rank[i] < hit_rank)) begin
          rank_next[i] = rank[i] + RANK_W'(1);
        end
      end else if (insert) begin
        if (slot_oh[i]) begin
          valid_next[i] = 1'b1;
          rank_next[i]  = '0;
        end else if (valid[i]) begin
          rank_next[i] = rank[i] + RANK_W'(1);
        end
      end
    end
    count_next = (insert && !evict) ? count + CNT_W'(1) : count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else if (fire) begin
      valid <= valid_next;
      count <= count_next;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank[i] <= rank_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (fire && key_we[i]) begin
        keys[i] <= req.key;
      end
      if (fire && value_we[i]) begin
        values[i] <= req.value;
      end
    end
  end

  always_comb begin
    rsp.found      = hit;
    rsp.evicted    = evict;
    rsp.read_value = is_put ? PUT_VALUE : (hit ? hit_value : MISS_VALUE);
  end

endmodule

@@ rtl/lru_key_value_cache.sv @@
// lru_key_value_cache: top level, request/response registers and handshake.
// Depends on lkvc_pkg, lkvc_if, lkvc_cfg, lkvc_store.
`timescale 1ns / 1ps

// LRU key-value cache. Each request word is a get (operation 0) or a put
// (operation 1) on a signed 32-bit key; each produces exactly one response
// word. A request is captured in an input register, looked up and applied to
// the entry array once the output register is free or being drained (all keys
// compared in parallel, all recency ranks updated at once), and the response
// lands in an output register. Throughput is one word per cycle unless the
// response side stalls; the response is valid once the request has passed
// the input and output registers. The rate is set by the combinational
// compare and registered update across all MAX_ENTRIES entries, which lets
// each request see the store exactly as the previous one left it. Capacity is
// written over APB at byte address 0 (reset 16; 0 acts as 1, values above
// MAX_ENTRIES saturate); lowering it evicts lazily, one entry per later put
// of a new key. Get misses return read_value -1, puts return read_value 0.
module lru_key_value_cache import lkvc_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  lkvc_req_if.sink              req,
  lkvc_rsp_if.source            rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [CAP_W-1:0] capacity;
  logic             in_valid;
  lkvc_req_t        in_word;
  logic             out_valid;
  lkvc_rsp_t        out_word;
  lkvc_rsp_t        result;
  logic             fire;

  lkvc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  // the held request is processed whenever the output register is free or
  // being drained this cycle
  assign fire      = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_word.operation <= req.operation;
      in_word.key       <= req.key;
      in_word.value     <= req.value;
    end
  end

  lkvc_store #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .capacity (capacity),
    .fire     (fire),
    .req      (in_word),
    .rsp      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_word <= result;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.found      = out_word.found;
  assign rsp.read_value = out_word.read_value;
  assign rsp.evicted    = out_word.evicted;

endmodule

@@ tb/tb.sv @@
// tb: self-checking bench for lru_key_value_cache, driving request words and checking responses
// against a cycle-free LRU mirror. Depends on lkvc_pkg, lkvc_if and the RTL top.
`timescale 1ns / 1ps

module tb;
  import lkvc_pkg::*;

  localparam int ENTRIES      = MAX_ENTRIES_DEF;
  localparam int KEY_POOL     = 20;   // a bit more than the store holds: hits and evictions
  localparam int HOLD_CYCLES  = 400;  // long response back-pressure, fills the pipe
  localparam int DRAIN_CYCLES = 6;    // idle margin after the last response

  logic clk = 1'b0;
  logic rst = 1'b1;

  // APB side; pready is tied high in the block
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  lkvc_req_if req_ch ();
  lkvc_rsp_if rsp_ch ();

  lru_key_value_cache dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Mirror of the store. Keys/values of an entry are only looked at while its
  // valid bit is set, so entries never written stay out of every comparison.
  // Rank 0 is the most recent entry; valid ranks are always 0..count-1.
  // ---------------------------------------------------------------------------
  logic [KEY_W-1:0]   mirror_key   [ENTRIES];
  logic [VALUE_W-1:0] mirror_value [ENTRIES];
  bit                 mirror_valid [ENTRIES];
  int unsigned        mirror_rank  [ENTRIES];
  int unsigned        mirror_count;
  logic [CAP_W-1:0]   mirror_capacity;

  logic [KEY_W-1:0] key_pool [KEY_POOL];

  lkvc_req_t req_pending  [$];  // words waiting for the driver
  lkvc_rsp_t rsp_expected [$];  // predicted responses, oldest first

  int send_pct     = 0;  // chance per cycle that the sender holds back
  int recv_pct     = 0;  // chance per cycle that the receiver stalls
  bit hold_request = 1'b0;
  bit hold_taken   = 1'b0;
  int hold_left    = 0;
  int errors       = 0;

  // Move entry s to rank 0; only entries more recent than it age by one.
  function automatic void promote_entry(int s);
    int unsigned r;
    r = mirror_rank[s];
    for (int i = 0; i < ENTRIES; i++)
      if (mirror_valid[i] && mirror_rank[i] < r) mirror_rank[i]++;
    mirror_rank[s] = 0;
  endfunction

  // Apply one get/put to the mirror and return the response it must produce.
  function automatic lkvc_rsp_t cache_apply(lkvc_req_t w);
    int          hit;
    int          free_slot;
    int          oldest;
    int          slot;
    int unsigned cap_eff;
    lkvc_rsp_t   o;
    hit       = -1;
    free_slot = -1;
    oldest    = -1;
    o         = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (mirror_valid[i]) begin
        if (mirror_key[i] == w.key) hit = i;
        if (oldest < 0 || mirror_rank[i] > mirror_rank[oldest]) oldest = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    // capacity 0 behaves as 1, anything above the array size saturates
    if (mirror_capacity == 0) cap_eff = 1;
    else if (mirror_capacity > ENTRIES) cap_eff = ENTRIES;
    else cap_eff = mirror_capacity;

    o.found = (hit >= 0);
    if (w.operation == OP_GET) begin
      if (hit >= 0) begin
        o.read_value = mirror_value[hit];
        promote_entry(hit);
      end else begin
        o.read_value = MISS_VALUE;
      end
    end else begin
      o.read_value = PUT_VALUE;
      if (hit >= 0) begin
        mirror_value[hit] = w.value;
        promote_entry(hit);
      end else begin
        slot = free_slot;
        // lazy shrink: after a capacity drop each new key evicts exactly one
        if ((mirror_count >= cap_eff || free_slot < 0) && oldest >= 0) begin
          mirror_valid[oldest] = 1'b0;
          if (mirror_count > 0) mirror_count--;
          slot      = oldest;
          o.evicted = 1'b1;
        end
        if (slot >= 0) begin
          for (int i = 0; i < ENTRIES; i++)
            if (mirror_valid[i]) mirror_rank[i]++;
          mirror_key[slot]   = w.key;
          mirror_value[slot] = w.value;
          mirror_valid[slot] = 1'b1;
          mirror_rank[slot]  = 0;
          mirror_count++;
        end
      end
    end
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: holds a word until it is taken, then maybe idles.
  // The mirror is advanced at the accepting edge, in acceptance order.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    lkvc_req_t taken;
    lkvc_req_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        taken.operation = req_ch.operation;
        taken.key       = req_ch.key;
        taken.value     = req_ch.value;
        rsp_expected.push_back(cache_apply(taken));
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (req_pending.size() != 0 && $urandom_range(99) >= send_pct) begin
          nxt = req_pending.pop_front();
          req_ch.valid     <= 1'b1;
          req_ch.operation <= nxt.operation;
          req_ch.key       <= nxt.key;
          req_ch.value     <= nxt.value;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response ready: random stalls, plus one long hold-off when asked for.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (hold_request && !hold_taken) begin
        hold_left  = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_pct);
      end
    end
  end

  // Response checker: every accepted word against the oldest prediction.
  always @(posedge clk) begin
    lkvc_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (rsp_expected.size() == 0) begin
        $error("response word with nothing expected");
        errors++;
      end else begin
        want = rsp_expected.pop_front();
        if (rsp_ch.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, rsp_ch.found);
          errors++;
        end
        if (rsp_ch.read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value, rsp_ch.read_value);
          errors++;
        end
        if (rsp_ch.evicted !== want.evicted) begin
          $error("evicted: expected %0d, got %0d", want.evicted, rsp_ch.evicted);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_word(logic op, logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v);
    lkvc_req_t w;
    w.operation = op;
    w.key       = k;
    w.value     = v;
    req_pending.push_back(w);
  endtask

  function automatic lkvc_req_t random_word();
    lkvc_req_t w;
    w.operation = $urandom_range(1) ? OP_PUT : OP_GET;
    // mostly keys from the pool so gets hit and puts replace; some fresh ones
    if ($urandom_range(9) == 0) w.key = $urandom;
    else w.key = key_pool[$urandom_range(KEY_POOL - 1)];
    case ($urandom_range(19))
      0:       w.value = 32'h8000_0000;
      1:       w.value = 32'h7fff_ffff;
      2:       w.value = '1;
      3:       w.value = '0;
      default: w.value = $urandom;
    endcase
    return w;
  endfunction

  // APB write: setup, then access; the register takes it in the access phase.
  task automatic set_capacity(int unsigned cap);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(4 * REG_CAPACITY);
    pwdata  <= APB_DATA_W'(cap);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    mirror_capacity = CAP_W'(cap);
  endtask

  // Idle point: nothing queued, nothing on the wire, nothing outstanding.
  task automatic drain();
    while (req_pending.size() != 0 || rsp_expected.size() != 0 || req_ch.valid)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(int unsigned cap, int sp, int rp, int count, bit hold);
    set_capacity(cap);
    // fresh key pool each phase; the corner keys stay in
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = '0;
    key_pool[3] = '1;
    for (int i = 4; i < KEY_POOL; i++) key_pool[i] = $urandom;
    @(negedge clk);
    send_pct     = sp;
    recv_pct     = rp;
    hold_request = hold;
    for (int i = 0; i < count; i++) req_pending.push_back(random_word());
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    req_ch.valid     = 1'b0;
    req_ch.operation = OP_GET;
    req_ch.key       = '0;
    req_ch.value     = '0;
    rsp_ch.ready     = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      mirror_valid[i] = 1'b0;
      mirror_rank[i]  = 0;
    end
    mirror_count    = 0;
    mirror_capacity = CAPACITY_RESET;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset capacity, field extremes, miss/hit, replace, fill, evict.
    @(negedge clk);
    queue_word(OP_GET, 32'h0000_0000, 32'h7fff_ffff);  // empty store, value ignored
    queue_word(OP_PUT, 32'h8000_0000, 32'h7fff_ffff);
    queue_word(OP_PUT, 32'h7fff_ffff, 32'h8000_0000);
    queue_word(OP_PUT, 32'h0000_0000, 32'h0000_0000);
    queue_word(OP_PUT, 32'hffff_ffff, 32'hffff_ffff);  // stored -1, not a miss
    queue_word(OP_GET, 32'h8000_0000, 32'h0000_0000);
    queue_word(OP_GET, 32'hffff_ffff, 32'h5a5a_5a5a);
    queue_word(OP_GET, 32'h1234_5678, 32'h0000_0000);  // miss
    queue_word(OP_PUT, 32'h7fff_ffff, 32'h0000_0001);  // replace existing value
    queue_word(OP_GET, 32'h7fff_ffff, 32'hffff_ffff);
    for (int i = 0; i < 12; i++)                       // fill all 16 slots
      queue_word(OP_PUT, 32'h1000_0000 + i, 32'ha5a5_0000 + i);
    queue_word(OP_PUT, 32'h2000_0000, 32'h0bad_cafe);  // full: evicts key 0
    queue_word(OP_GET, 32'h0000_0000, 32'h0000_0000);  // gone
    queue_word(OP_GET, 32'h8000_0000, 32'h0000_0000);  // survived
    drain();

    // Random phases: capacity settings incl. 0, 1, max and saturating values.
    run_phase(31, 0,  0,  300, 1'b0);  // above max, acts as 16
    run_phase(3,  83, 0,  300, 1'b0);  // dropped below count: lazy eviction
    run_phase(0,  0,  83, 200, 1'b0);  // acts as 1
    run_phase(1,  28, 28, 200, 1'b0);
    run_phase(16, 0,  0,  250, 1'b1);  // long response hold-off, input stalls
    run_phase(17, 28, 28, 200, 1'b0);  // just above max
    run_phase(8,  0,  83, 200, 1'b0);

    if (errors == 0) begin
      $display("lru_key_value_cache verification clean");
    end else begin
      $display("lru_key_value_cache verification failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("lru_key_value_cache verification failed");
    $finish;
  end

endmodule
